FILE: design/cd_mode2_sector_checker_assert.svh
// assertion macros shared by the sector checker modules
`ifndef CD_MODE2_SECTOR_CHECKER_ASSERT_SVH
`define CD_MODE2_SECTOR_CHECKER_ASSERT_SVH
`ifndef ASSERT_OFF
`define CDM2_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("cdm2 assertion failed");
`define CDM2_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("cdm2 forbidden condition seen");
`else
`define CDM2_ASSERT(lbl, prop)
`define CDM2_NEVER(lbl, expr)
`endif
`endif

FILE: design/cdm2_pkg.sv
// constants, types and helper functions of the mode 2 sector checker
package cdm2_pkg;

	localparam int SectorBytes = 2352;
	localparam int OffW        = 12;
	localparam int MemAw       = 13;
	localparam int MemDepth    = 2 * SectorBytes;
	localparam int AddrLo      = 12;
	localparam int AddrHi      = 16;
	localparam int EdcStart    = 16;
	localparam int SubmodeAt   = 18;
	localparam int Form2Bit    = 5;
	localparam int F1EdcLen    = 'h808;
	localparam int F1EdcAt     = 'h818;
	localparam int F2EdcLen    = 'h91C;
	localparam int F2EdcAt     = 'h92C;
	localparam int PAt         = 'h81C;
	localparam int QAt         = 'h8C8;
	localparam int PHalf       = 86;
	localparam int QHalf       = 52;

	// pass geometry
	localparam int PMinors = 24;
	localparam int PMult   = 2;
	localparam int PInc    = 86;
	localparam int QMinors = 43;
	localparam int QMult   = 86;
	localparam int QInc    = 88;
	localparam int PSize   = PHalf * PMinors;
	localparam int QSize   = QHalf * QMinors;

	localparam logic [31:0] EdcPoly = 32'hD801_8001;
	localparam logic [7:0]  GfLow   = 8'h1D;
	localparam logic [7:0]  GfInv3  = 8'hF4;

	typedef struct packed {
		logic             en;
		logic [MemAw-1:0] addr;
		logic [7:0]       data;
	} mem_wr_t;

	typedef struct packed {
		logic bank;
		logic form2;
		logic edc_bad;
	} job_t;

	typedef struct packed {
		logic en;
		logic bank;
	} rel_t;

	function automatic logic [7:0] gf_mul2(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? GfLow : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 7; i >= 0; i--) begin
			p = gf_mul2(p) ^ (b[i] ? a : 8'h00);
		end
		return p;
	endfunction

	function automatic logic [31:0] edc_byte(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] j;
		j = {24'h0, acc[7:0] ^ b};
		for (int k = 0; k < 8; k++) begin
			j = (j >> 1) ^ (j[0] ? EdcPoly : 32'h0);
		end
		return (acc >> 8) ^ j;
	endfunction

	function automatic logic [MemAw-1:0] mem_addr(input logic bank, input logic [OffW-1:0] off);
		return {1'b0, off} + (bank ? MemAw'(SectorBytes) : '0);
	endfunction

endpackage

FILE: design/cdm2_front.sv
// front end: byte intake, position count, edc and job hand-off
module cdm2_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,
	input  logic                s_axis_tuser,
	input  cdm2_pkg::rel_t      rel,
	output cdm2_pkg::mem_wr_t   wr,
	output logic                push,
	output cdm2_pkg::job_t      job
);

	logic [cdm2_pkg::OffW-1:0] pos_q;
	logic [cdm2_pkg::OffW-1:0] pos;
	logic [31:0]               acc_q;
	logic [31:0]               snap_q;
	logic [31:0]               f1w_q;
	logic [23:0]               f2w_q;
	logic                      form2_q;
	logic [1:0]                busy_q;
	logic                      wbank_q;
	logic                      fire;
	logic                      last;
	logic [31:0]               acc_in;
	logic [31:0]               acc_new;
	logic [31:0]               f2word;
	logic [1:0]                busy_n;

	assign s_axis_tready = !busy_q[wbank_q];
	assign fire   = s_axis_tvalid && s_axis_tready;
	assign pos    = s_axis_tuser ? '0 : pos_q;
	assign last   = pos == cdm2_pkg::OffW'(cdm2_pkg::SectorBytes - 1);
	assign acc_in = (pos == '0) ? 32'h0 : acc_q;

	always_comb begin
		acc_new = acc_in;
		if (pos >= cdm2_pkg::OffW'(cdm2_pkg::EdcStart) &&
		    pos < cdm2_pkg::OffW'(cdm2_pkg::EdcStart + cdm2_pkg::F2EdcLen)) begin
			acc_new = cdm2_pkg::edc_byte(acc_in, s_axis_tdata);
		end
	end

	// the form 2 word ends on the last sector byte
	assign f2word = {s_axis_tdata, f2w_q};

	always_comb begin
		job.bank  = wbank_q;
		job.form2 = form2_q;
		if (form2_q) begin
			job.edc_bad = (f2word != 32'h0) && (f2word != acc_new);
		end else begin
			job.edc_bad = f1w_q != snap_q;
		end
	end

	assign push = fire && last;

	assign wr.en   = fire;
	assign wr.addr = cdm2_pkg::mem_addr(wbank_q, pos);
	assign wr.data = s_axis_tdata;

	always_comb begin
		busy_n = busy_q;
		if (rel.en) begin
			busy_n[rel.bank] = 1'b0;
		end
		if (push) begin
			busy_n[wbank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			acc_q   <= '0;
			snap_q  <= '0;
			form2_q <= 1'b0;
			busy_q  <= '0;
			wbank_q <= 1'b0;
		end else begin
			busy_q <= busy_n;
			if (fire) begin
				pos_q <= last ? '0 : pos + 1'b1;
				acc_q <= acc_new;
				if (pos == cdm2_pkg::OffW'(cdm2_pkg::EdcStart + cdm2_pkg::F1EdcLen - 1)) begin
					snap_q <= acc_new;
				end
				if (pos == cdm2_pkg::OffW'(cdm2_pkg::SubmodeAt)) begin
					form2_q <= s_axis_tdata[cdm2_pkg::Form2Bit];
				end
				if (push) begin
					wbank_q <= !wbank_q;
				end
			end
		end
	end

	// stored edc words, both start on a multiple of four
	always_ff @(posedge clk) begin
		if (fire) begin
			if (pos[cdm2_pkg::OffW-1:2] == 10'(cdm2_pkg::F1EdcAt / 4)) begin
				f1w_q[pos[1:0]*8 +: 8] <= s_axis_tdata;
			end
			if (pos[cdm2_pkg::OffW-1:2] == 10'(cdm2_pkg::F2EdcAt / 4) && pos[1:0] != 2'd3) begin
				f2w_q[pos[1:0]*8 +: 8] <= s_axis_tdata;
			end
		end
	end

endmodule

FILE: design/cdm2_jobq.sv
// two-entry job queue between front and back
`include "cd_mode2_sector_checker_assert.svh"
module cdm2_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cdm2_pkg::job_t job_in,
	output logic           job_valid,
	output cdm2_pkg::job_t job_out,
	input  logic           pop
);

	cdm2_pkg::job_t ent_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	assign job_valid = cnt_q != 2'd0;
	assign job_out   = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= job_in;
		end
	end

	`CDM2_NEVER(a_no_push_full, push && cnt_q == 2'd2)
	`CDM2_NEVER(a_no_pop_empty, pop && cnt_q == 2'd0)

endmodule

FILE: design/cdm2_back.sv
// back end: sector store, p and q parity passes, result register
`include "cd_mode2_sector_checker_assert.svh"
module cdm2_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cdm2_pkg::mem_wr_t wr,
	input  logic              job_valid,
	input  cdm2_pkg::job_t    job_in,
	output logic              pop,
	output cdm2_pkg::rel_t    rel,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PPASS = 5'b00010,
		ST_QPASS = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	localparam int OffW = cdm2_pkg::OffW;

	logic [7:0] mem_q  [cdm2_pkg::MemDepth];
	logic [7:0] plo_q  [cdm2_pkg::PHalf];
	logic [7:0] phi_q  [cdm2_pkg::PHalf];

	state_t         state_q;
	cdm2_pkg::job_t job_q;
	logic [6:0]     major_q;
	logic [5:0]     minor_q;
	logic [OffW-1:0] idx_q;
	logic [OffW-1:0] base_q;
	logic           pbad_q;
	logic           qbad_q;
	logic           out_v_q;
	logic [3:0]     out_q;

	logic           qp;
	logic           issue;
	logic [6:0]     majors;
	logic [5:0]     minors;
	logic [OffW-1:0] mult;
	logic [OffW-1:0] inc;
	logic [OffW-1:0] size;
	logic [OffW-1:0] off;
	logic [OffW-1:0] pidx;
	logic           p_hi_sel;
	logic [6:0]     paddr;
	logic [OffW-1:0] st_off;
	logic [OffW-1:0] idx_step;
	logic [OffW-1:0] idx_wrap;
	logic           last_minor;
	logic           last_major;
	logic           out_free;

	// issue -> data stage
	logic           v_s1;
	logic           first_s1;
	logic           last_s1;
	logic           zero_s1;
	logic           psel_s1;
	logic           phi_s1;
	logic           stlo_s1;
	logic           sthi_s1;
	logic [6:0]     major_s1;
	logic           qp_s1;
	logic [7:0]     rd1_q;
	logic [7:0]     rd2_q;
	logic [7:0]     prlo_q;
	logic [7:0]     prhi_q;
	logic [7:0]     a_q;
	logic [7:0]     b_q;
	logic [7:0]     st_lo_q;
	logic [7:0]     st_hi_q;

	// finish stage
	logic           fin_v_s2;
	logic [7:0]     fa_s2;
	logic [7:0]     fb_s2;
	logic [6:0]     major_s2;
	logic           qp_s2;

	logic [7:0]     t;
	logic [7:0]     a_in;
	logic [7:0]     b_in;
	logic [7:0]     a_next;
	logic [7:0]     b_next;
	logic [7:0]     r;
	logic [7:0]     h;

	assign qp     = state_q == ST_QPASS;
	assign issue  = state_q == ST_PPASS || state_q == ST_QPASS;
	assign majors = qp ? 7'(cdm2_pkg::QHalf) : 7'(cdm2_pkg::PHalf);
	assign minors = qp ? 6'(cdm2_pkg::QMinors) : 6'(cdm2_pkg::PMinors);
	assign mult   = qp ? OffW'(cdm2_pkg::QMult) : OffW'(cdm2_pkg::PMult);
	assign inc    = qp ? OffW'(cdm2_pkg::QInc) : OffW'(cdm2_pkg::PInc);
	assign size   = qp ? OffW'(cdm2_pkg::QSize) : OffW'(cdm2_pkg::PSize);

	assign off      = idx_q + OffW'(cdm2_pkg::AddrLo);
	assign pidx     = off - OffW'(cdm2_pkg::PAt);
	assign p_hi_sel = pidx[7:0] >= 8'(cdm2_pkg::PHalf);
	assign paddr    = p_hi_sel ? 7'(pidx[7:0] - 8'(cdm2_pkg::PHalf)) : pidx[6:0];

	// stored parity bytes are fetched on the second port at minors two and three
	assign st_off = (qp ? OffW'(cdm2_pkg::QAt) : OffW'(cdm2_pkg::PAt)) + OffW'(major_q) +
	                ((minor_q == 6'd3) ? OffW'(majors) : '0);

	assign idx_step   = idx_q + inc;
	assign idx_wrap   = (idx_step >= size) ? idx_step - size : idx_step;
	assign last_minor = minor_q == minors - 1'b1;
	assign last_major = major_q == majors - 1'b1;

	assign out_free = !out_v_q || m_axis_tready;
	assign pop      = state_q == ST_IDLE && job_valid;
	assign rel.en   = state_q == ST_DONE && out_free;
	assign rel.bank = job_q.bank;

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {4'h0, out_q};

	// memories
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd1_q <= mem_q[cdm2_pkg::mem_addr(job_q.bank, off)];
		rd2_q <= mem_q[cdm2_pkg::mem_addr(job_q.bank, st_off)];
	end

	always_ff @(posedge clk) begin
		if (fin_v_s2 && !qp_s2) begin
			plo_q[major_s2] <= r;
			phi_q[major_s2] <= h;
		end
		prlo_q <= plo_q[paddr];
		prhi_q <= phi_q[paddr];
	end

	// data stage: one byte into the column or diagonal accumulators
	always_comb begin
		if (zero_s1) begin
			t = 8'h00;
		end else if (psel_s1) begin
			t = phi_s1 ? prhi_q : prlo_q;
		end else begin
			t = rd1_q;
		end
		a_in   = first_s1 ? 8'h00 : a_q;
		b_in   = first_s1 ? 8'h00 : b_q;
		a_next = cdm2_pkg::gf_mul2(a_in ^ t);
		b_next = b_in ^ t;
	end

	// finish stage: solve for the two parity bytes
	assign r = cdm2_pkg::gf_mul(cdm2_pkg::gf_mul2(fa_s2) ^ fb_s2, cdm2_pkg::GfInv3);
	assign h = r ^ fb_s2;

	always_ff @(posedge clk) begin
		first_s1 <= minor_q == '0;
		last_s1  <= last_minor;
		zero_s1  <= off < OffW'(cdm2_pkg::AddrHi);
		psel_s1  <= off >= OffW'(cdm2_pkg::PAt);
		phi_s1   <= p_hi_sel;
		stlo_s1  <= issue && minor_q == 6'd2;
		sthi_s1  <= issue && minor_q == 6'd3;
		major_s1 <= major_q;
		qp_s1    <= qp;
		if (v_s1) begin
			a_q <= a_next;
			b_q <= b_next;
		end
		if (stlo_s1) begin
			st_lo_q <= rd2_q;
		end
		if (sthi_s1) begin
			st_hi_q <= rd2_q;
		end
		fa_s2    <= a_next;
		fb_s2    <= b_next;
		major_s2 <= major_s1;
		qp_s2    <= qp_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			fin_v_s2 <= 1'b0;
		end else begin
			v_s1     <= issue;
			fin_v_s2 <= v_s1 && last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q   <= '0;
			major_q <= '0;
			minor_q <= '0;
			idx_q   <= '0;
			base_q  <= '0;
			pbad_q  <= 1'b0;
			qbad_q  <= 1'b0;
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else begin
			if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			if (fin_v_s2) begin
				if (qp_s2) begin
					qbad_q <= qbad_q || r != st_lo_q || h != st_hi_q;
				end else begin
					pbad_q <= pbad_q || r != st_lo_q || h != st_hi_q;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q   <= job_in;
						pbad_q  <= 1'b0;
						qbad_q  <= 1'b0;
						major_q <= '0;
						minor_q <= '0;
						idx_q   <= '0;
						base_q  <= '0;
						state_q <= job_in.form2 ? ST_DONE : ST_PPASS;
					end
				end
				ST_PPASS, ST_QPASS: begin
					if (last_minor) begin
						minor_q <= '0;
						if (last_major) begin
							major_q <= '0;
							idx_q   <= '0;
							base_q  <= '0;
							state_q <= qp ? ST_DRAIN : ST_QPASS;
						end else begin
							major_q <= major_q + 1'b1;
							if (major_q[0]) begin
								base_q <= base_q + mult;
								idx_q  <= base_q + mult;
							end else begin
								idx_q <= base_q + 1'b1;
							end
						end
					end else begin
						minor_q <= minor_q + 1'b1;
						idx_q   <= idx_wrap;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !fin_v_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						out_q   <= {job_q.form2, qbad_q, pbad_q, job_q.edc_bad};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`CDM2_NEVER(a_fin_outside_pass, fin_v_s2 && (state_q == ST_IDLE || state_q == ST_DONE))
	`CDM2_NEVER(a_form2_no_parity, m_axis_tvalid && m_axis_tdata[3] && m_axis_tdata[2:1] != 2'b00)

endmodule

FILE: design/cd_mode2_sector_checker.sv
// top level of the cd-rom mode 2 sector edc and ecc checker
// input channel s_axis: one raw sector byte per word, tuser marks offset 0 of a new
// sector; a sector is 2352 bytes and the count also wraps by itself after the last one.
// output channel m_axis: one status word per complete sector, given after its last byte.
// bytes are taken at one per cycle while tready is high, into one of two sector
// banks; the other is the checker's. tready drops only if both hold unfinished sectors.
// form 1 check: p pass over 2064 stored bytes then q pass over 2236 bytes, one
// byte read per cycle, before the status word is given.
// form 2 sectors skip the parity passes and go straight to the status word.
// the sustained form 1 rate is set by the parity passes, form 2 by the byte intake.
// reset clears the byte count, edc state, bank ownership and the result register;
// the sector store itself is not cleared, every byte is written before it is read.
// if the receiver stalls, the finished status waits in the output register, the
// checker holds its next sector, and input keeps flowing into the free bank.
module cd_mode2_sector_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tuser,   // [0] sector_start
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [0] edc_bad [1] p_parity_bad [2] q_parity_bad
	                                   // [3] form2_sector [7:4] zero
);

	cdm2_pkg::mem_wr_t wr;
	cdm2_pkg::rel_t    rel;
	cdm2_pkg::job_t    job_push;
	cdm2_pkg::job_t    job_head;
	logic              push;
	logic              pop;
	logic              job_valid;

	// byte intake, edc and sector bookkeeping
	cdm2_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.rel           (rel),
		.wr            (wr),
		.push          (push),
		.job           (job_push)
	);

	// finished sectors waiting for the parity engine
	cdm2_jobq u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.job_in    (job_push),
		.job_valid (job_valid),
		.job_out   (job_head),
		.pop       (pop)
	);

	// sector store, p/q recompute and status register
	cdm2_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr            (wr),
		.job_valid     (job_valid),
		.job_in        (job_head),
		.pop           (pop),
		.rel           (rel),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
